// ----- rtl/zst_pkg.sv -----
// Shared types, constants and the thinning decision for the Zhang-Suen pass.
package zst_pkg;

    localparam int PixW          = 8;
    localparam int WidthFieldW   = 11;
    localparam int HeightFieldW  = 12;
    localparam int RowW          = 13;   // rows run past the image height while draining
    localparam int CfgDataW      = 12;
    localparam int CfgIdxW       = 1;
    localparam int DefMaxWidth   = 1024;
    localparam int DefWidth      = 640;
    localparam int DefHeight     = 480;
    localparam int MinDim        = 3;

    localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'd0;
    localparam logic [CfgIdxW-1:0] RegImageHeight = 1'd1;

    localparam logic ModePixel = 1'b0;
    localparam logic ModeFlush = 1'b1;

    typedef logic [PixW-1:0] pix_t;
    typedef pix_t [8:0] win_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
    } line_pair_t;

    typedef struct packed {
        logic advance;
        logic interior;
    } stage_ctrl_t;

    // Ring order P2..P9 maps onto window taps 1,2,5,8,7,6,3,0.
    function automatic logic must_clear(win_t w, logic second);
        logic [7:0] r;
        logic [3:0] cnt;
        logic [3:0] trans;
        logic       blocked;
        r[0] = w[1] != '0;
        r[1] = w[2] != '0;
        r[2] = w[5] != '0;
        r[3] = w[8] != '0;
        r[4] = w[7] != '0;
        r[5] = w[6] != '0;
        r[6] = w[3] != '0;
        r[7] = w[0] != '0;
        cnt   = '0;
        trans = '0;
        for (int i = 0; i < 8; i++)
        begin
            cnt   = cnt + {3'b000, r[i]};
            trans = trans + {3'b000, (!r[i] && r[(i + 1) % 8])};
        end
        // r[0]=P2, r[2]=P4, r[4]=P6, r[6]=P8
        if (second)
            blocked = (r[0] && r[2] && r[6]) || (r[0] && r[4] && r[6]);
        else
            blocked = (r[0] && r[2] && r[4]) || (r[2] && r[4] && r[6]);
        return (cnt >= 4'd2) && (cnt <= 4'd6) && (trans == 4'd1) && !blocked;
    endfunction

endpackage

// ----- rtl/zst_line_store.sv -----
// Two-row line store: one entry per column holds the pixels of the two rows above.
module zst_line_store #(
    parameter int Depth = zst_pkg::DefMaxWidth
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(Depth)-1:0]  waddr,
    input  zst_pkg::line_pair_t       wdata,
    input  logic [$clog2(Depth)-1:0]  raddr,
    output zst_pkg::line_pair_t       rdata
);
    import zst_pkg::*;

    line_pair_t mem [Depth];
    line_pair_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/zst_window_stage.sv -----
// 3x3 window and the per-centre clear decision of one sub-iteration.
module zst_window_stage #(
    parameter logic Second = 1'b0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  zst_pkg::stage_ctrl_t ctrl,
    input  zst_pkg::pix_t        top,
    input  zst_pkg::pix_t        mid,
    input  zst_pkg::pix_t        value,
    output zst_pkg::pix_t        center,
    output logic                 clear
);
    import zst_pkg::*;

    win_t win_reg;
    win_t win_next;

    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = top;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = mid;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = value;
    end

    assign center = win_next[4];
    assign clear  = ctrl.interior && (win_next[4] != '0) && must_clear(win_next, Second);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (ctrl.advance)
            win_reg <= win_next;
    end

endmodule

// ----- rtl/zhang_suen_thinning_pass_core.sv -----
// Top level: one Zhang-Suen thinning iteration over a raster-order pixel stream.
// Takes one item per clock whenever the output register is free or being emptied,
// so a full frame is W*H pixels plus 2*W+2 flush items, with no stall from the
// block itself. Each result trails its pixel by 2*W+2 accepted items (two
// window stages of W+1 each) and then passes through the output register.
// Both sub-iterations run in the same cycle; each line store is one RAM with a
// registered read that is addressed one column ahead. The line stores need no
// clearing after reset. A flush item during the pixel phase is dropped; any
// item after the last pixel is a flush. Writing either geometry register
// restarts the frame; the last result carries tlast and, in tuser, whether any
// pixel of the frame was cleared.
module zhang_suen_thinning_pass_core #(
    parameter int MaxWidth = zst_pkg::DefMaxWidth
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] pixel_value
    input  logic                         s_tuser,   // [0] mode
    // results
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [7:0] out_pixel
    output logic                         m_tlast,   // last_pixel
    output logic                         m_tuser,   // [0] frame_changed
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [zst_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [zst_pkg::CfgDataW-1:0] cfg_wdata
);
    import zst_pkg::*;

    localparam int XW = (MaxWidth > 2047) ? WidthFieldW : $clog2(MaxWidth + 1);
    localparam int AW = $clog2(MaxWidth);
    localparam int ResetWidth = (DefWidth > MaxWidth) ? MaxWidth : DefWidth;

    logic [XW-1:0]           width_reg,  width_next;
    logic [HeightFieldW-1:0] height_reg, height_next;
    logic [XW-1:0]           x0_reg, x0_next;
    logic [RowW-1:0]         y0_reg, y0_next;
    logic                    changed_reg, changed_next;

    logic                    m_valid_reg;
    pix_t                    m_data_reg;
    logic                    m_last_reg;
    logic                    m_changed_reg;

    logic [WidthFieldW-1:0]  cfg_w;
    logic [HeightFieldW-1:0] cfg_h;
    logic [RowW-1:0]         h_ext, h_m1;
    logic [XW-1:0]           w_m1;

    logic                    accept, pix_phase, drop, adv, adv2;
    pix_t                    v, m, center1, center2;
    logic                    valid1, valid2, interior1, interior2;
    logic [XW-1:0]           col1, col2;
    logic [RowW-1:0]         row1, row2;
    logic                    clear1, clear2, clr1_eff, clr2_eff;
    logic                    out_fire, last, end_frame;
    stage_ctrl_t             ctrl1, ctrl2;

    line_pair_t              rd1, rd2, wd1, wd2;
    logic [AW-1:0]           raddr1, raddr2;
    logic [XW-1:0]           next_col1;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign h_ext = {1'b0, height_reg};
    assign h_m1  = h_ext - RowW'(1);
    assign w_m1  = width_reg - XW'(1);

    assign pix_phase = y0_reg < h_ext;
    assign drop      = pix_phase && (s_tuser == ModeFlush);
    assign adv       = accept && !drop;
    assign v         = pix_phase ? s_tdata : '0;

    // centre of stage one sits W+1 items behind the input position
    assign valid1 = (y0_reg >= RowW'(2)) || ((y0_reg == RowW'(1)) && (x0_reg != '0));
    assign col1   = (x0_reg == '0) ? w_m1 : x0_reg - XW'(1);
    assign row1   = (x0_reg == '0) ? y0_reg - RowW'(2) : y0_reg - RowW'(1);
    assign interior1 = valid1 && (col1 != '0) && (col1 < w_m1)
                       && (row1 != '0) && (row1 < h_m1);

    assign valid2 = (row1 >= RowW'(2)) || ((row1 == RowW'(1)) && (col1 != '0));
    assign col2   = (col1 == '0) ? w_m1 : col1 - XW'(1);
    assign row2   = (col1 == '0) ? row1 - RowW'(2) : row1 - RowW'(1);
    assign interior2 = valid2 && (col2 != '0) && (col2 < w_m1)
                       && (row2 != '0) && (row2 < h_m1);

    assign ctrl1 = '{advance: adv, interior: interior1};
    assign ctrl2 = '{advance: adv2, interior: interior2};

    zst_window_stage #(.Second(1'b0)) u_stage1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl1),
        .top    (rd1.top),
        .mid    (rd1.mid),
        .value  (v),
        .center (center1),
        .clear  (clear1)
    );

    // centres past the image bottom feed zeros into stage two
    assign m    = (clear1 || (row1 >= h_ext)) ? '0 : center1;
    assign adv2 = adv && valid1;

    zst_window_stage #(.Second(1'b1)) u_stage2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl2),
        .top    (rd2.top),
        .mid    (rd2.mid),
        .value  (m),
        .center (center2),
        .clear  (clear2)
    );

    assign clr1_eff  = adv && clear1;
    assign clr2_eff  = adv2 && clear2;
    assign out_fire  = adv2 && valid2;
    assign last      = (row2 == h_m1) && (col2 == w_m1);
    assign end_frame = out_fire && (last || (row2 >= h_ext));

    assign wd1 = '{top: rd1.mid, mid: v};
    assign wd2 = '{top: rd2.mid, mid: m};

    // read addresses follow the position of the next item
    assign next_col1 = (x0_next == '0) ? width_next - XW'(1) : x0_next - XW'(1);
    assign raddr1    = AW'(x0_next);
    assign raddr2    = AW'(next_col1);

    zst_line_store #(.Depth(MaxWidth)) u_raw_store (
        .clk   (clk),
        .we    (adv),
        .waddr (AW'(x0_reg)),
        .wdata (wd1),
        .raddr (raddr1),
        .rdata (rd1)
    );

    zst_line_store #(.Depth(MaxWidth)) u_mid_store (
        .clk   (clk),
        .we    (adv2),
        .waddr (AW'(col1)),
        .wdata (wd2),
        .raddr (raddr2),
        .rdata (rd2)
    );

    assign cfg_w = cfg_wdata[WidthFieldW-1:0];
    assign cfg_h = cfg_wdata[HeightFieldW-1:0];

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        x0_next      = x0_reg;
        y0_next      = y0_reg;
        changed_next = changed_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                RegImageWidth:
                begin
                    if (cfg_w < WidthFieldW'(MinDim))
                        width_next = XW'(MinDim);
                    else if (32'(cfg_w) > 32'(MaxWidth))
                        width_next = XW'(MaxWidth);
                    else
                        width_next = XW'(cfg_w);
                    x0_next      = '0;
                    y0_next      = '0;
                    changed_next = 1'b0;
                end
                RegImageHeight:
                begin
                    if (cfg_h < HeightFieldW'(MinDim))
                        height_next = HeightFieldW'(MinDim);
                    else
                        height_next = cfg_h;
                    x0_next      = '0;
                    y0_next      = '0;
                    changed_next = 1'b0;
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
        else if (adv)
        begin
            if (end_frame)
            begin
                x0_next      = '0;
                y0_next      = '0;
                changed_next = 1'b0;
            end
            else
            begin
                if (x0_reg == w_m1)
                begin
                    x0_next = '0;
                    y0_next = y0_reg + RowW'(1);
                end
                else
                begin
                    x0_next = x0_reg + XW'(1);
                end
                changed_next = changed_reg || clr1_eff || clr2_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= XW'(ResetWidth);
            height_reg  <= HeightFieldW'(DefHeight);
            x0_reg      <= '0;
            y0_reg      <= '0;
            changed_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            x0_reg      <= x0_next;
            y0_reg      <= y0_next;
            changed_reg <= changed_next;
            if (s_tready)
                m_valid_reg <= out_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            m_data_reg    <= clear2 ? '0 : center2;
            m_last_reg    <= last;
            m_changed_reg <= last && (changed_reg || clr1_eff || clr2_eff);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_changed_reg;

endmodule
